[design/grid_point_cell_blanking_top_defines.svh]
// Assertion macros shared by the grid point/cell blanking RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef GRID_POINT_CELL_BLANKING_TOP_DEFINES_SVH
`define GRID_POINT_CELL_BLANKING_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GPCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/gpcb_pkg.sv]
// Package for the grid point/cell blanking block: payload structs, codes,
// sequencer states and the request/response types of the shared ALU.
// No dependencies.
`default_nettype none

package gpcb_pkg;

  // Internal value width. Values saturate at all ones, which lies above any
  // supported mask depth (up to 2**24 entries).
  localparam int VW    = 25;
  localparam int MUL_BW = 17;
  localparam int IDX_W = 16;
  localparam int DIM_W = 17;
  localparam int FLAG_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam int STEP_W = 4;
  localparam logic [VW-1:0] SAT_MAX = {VW{1'b1}};

  // Item function codes.
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_POINT = 2'd1;
  localparam logic [1:0] FUNC_CELL  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_FLAG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_FLAG  = 3'd4;

  typedef struct packed {
    logic [1:0]        func;
    logic [IDX_W-1:0]  item_index;
    logic              mask_bit;
    logic [FLAG_W-1:0] ghost_in;
  } in_item_t;

  typedef struct packed {
    logic [FLAG_W-1:0] ghost_out;
    logic              hidden;
    logic              bad_index;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]  points_x;
    logic [DIM_W-1:0]  points_y;
    logic [DIM_W-1:0]  points_z;
    logic [FLAG_W-1:0] point_hidden_flag;
    logic [FLAG_W-1:0] cell_hidden_flag;
  } cfg_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t       op;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic          cin;
  } alu_req_t;

  typedef struct packed {
    logic [VW-1:0] res;
    logic          ge;
  } alu_rsp_t;

  typedef struct packed {
    logic we;
    logic wbit;
  } mem_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PSL,
    S_TOT,
    S_PCHK,
    S_PWR,
    S_PRD,
    S_PDAT,
    S_CSL,
    S_CCNT,
    S_CCHK,
    S_DIV1,
    S_DIV2,
    S_B1,
    S_B2,
    S_B3,
    S_B4,
    S_T1,
    S_T2,
    S_T3,
    S_CA,
    S_CB,
    S_CRD,
    S_CORN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[design/gpcb_alu.sv]
// Shared arithmetic unit: saturating multiply, saturating add with carry in,
// and a restoring subtract that also serves as compare. Uses gpcb_pkg.
`default_nettype none

module gpcb_alu (
  input  gpcb_pkg::alu_req_t req,
  output gpcb_pkg::alu_rsp_t rsp
);
  import gpcb_pkg::*;

  logic [VW+MUL_BW-1:0] prod;
  logic [VW:0]          sum;
  logic [VW-1:0]        diff;
  logic                 ge;

  always_comb begin
    prod = (VW+MUL_BW)'(req.a) * (VW+MUL_BW)'(req.b[MUL_BW-1:0]);
    sum  = (VW+1)'(req.a) + (VW+1)'(req.b) + (VW+1)'(req.cin);
    ge   = (req.a >= req.b);
    diff = req.a - req.b;
  end

  always_comb begin
    rsp.ge = ge;
    case (req.op)
      ALU_MUL: begin
        // Saturate: any product past VW bits reads as all ones.
        rsp.res = (|prod[VW+MUL_BW-1:VW]) ? SAT_MAX : prod[VW-1:0];
      end
      ALU_ADD: begin
        rsp.res = sum[VW] ? SAT_MAX : sum[VW-1:0];
      end
      ALU_SUB: begin
        // Restoring step: keep the minuend when it is below the subtrahend.
        rsp.res = ge ? diff : req.a;
      end
      default: begin
        rsp.res = req.a;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/gpcb_mask_mem.sv]
// One-bit valid mask store, one write or read address per cycle,
// registered read data. Uses gpcb_pkg for the request struct.
`default_nettype none

module gpcb_mask_mem #(
  parameter int MASK_DEPTH = 65536,
  localparam int AW = $clog2(MASK_DEPTH)
) (
  input  logic               clk,
  input  gpcb_pkg::mem_req_t req,
  input  logic [AW-1:0]      addr,
  output logic               rdata
);
  import gpcb_pkg::*;

  logic mask [MASK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mask[addr] <= req.wbit;
    end
    rdata <= mask[addr];
  end

endmodule

`default_nettype wire

[design/gpcb_seq.sv]
// Sequencer for the blanking block: walks each item through the shared ALU,
// a 16-step restoring division per axis split, and corner reads of the mask.
// Uses gpcb_pkg and the assertion macros header.
`default_nettype none
`include "grid_point_cell_blanking_top_defines.svh"

module gpcb_seq #(
  parameter int MASK_DEPTH = 65536,
  localparam int AW = $clog2(MASK_DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  gpcb_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  gpcb_pkg::in_item_t  in_data,
  output logic                res_valid,
  input  logic                res_take,
  output gpcb_pkg::out_item_t res_data,
  output gpcb_pkg::alu_req_t  alu_req,
  input  gpcb_pkg::alu_rsp_t  alu_rsp,
  output gpcb_pkg::mem_req_t  mem_req,
  output logic [AW-1:0]       mem_addr,
  input  logic                mem_rdata
);
  import gpcb_pkg::*;

  localparam logic [VW-1:0] DEPTH_V = VW'(MASK_DEPTH);
  localparam logic [STEP_W-1:0] STEP_LAST = {STEP_W{1'b1}};

  state_t state, state_next;

  in_item_t          item;
  logic [STEP_W-1:0] step;
  logic [VW-1:0]     pslice, total, cslice, acc, base, rem;
  logic [IDX_W-1:0]  quo, ck, cj, ci;
  logic [2:0]        corner;
  logic              all_ok, res_hidden, res_bad;

  logic [DIM_W-1:0]  cx, cy, cz;
  logic              dx, dy, dz;
  logic [VW-1:0]     idx_v, div_a;
  logic              accept, idx_over, acc_over;

  always_comb begin
    cx = (cfg.points_x > DIM_W'(1)) ? cfg.points_x - DIM_W'(1) : DIM_W'(1);
    cy = (cfg.points_y > DIM_W'(1)) ? cfg.points_y - DIM_W'(1) : DIM_W'(1);
    cz = (cfg.points_z > DIM_W'(1)) ? cfg.points_z - DIM_W'(1) : DIM_W'(1);
    dx = (cfg.points_x > DIM_W'(1));
    dy = (cfg.points_y > DIM_W'(1));
    dz = (cfg.points_z > DIM_W'(1));
    idx_v    = VW'(item.item_index);
    div_a    = {rem[VW-2:0], quo[IDX_W-1]};
    idx_over = (idx_v >= DEPTH_V);
    acc_over = (acc >= DEPTH_V);
    accept   = in_valid && !in_stall;
  end

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res_data.hidden    = res_hidden;
    res_data.bad_index = res_bad;
    if (!res_hidden) begin
      res_data.ghost_out = item.ghost_in;
    end else if (item.func == FUNC_CELL) begin
      res_data.ghost_out = item.ghost_in | cfg.cell_hidden_flag;
    end else begin
      res_data.ghost_out = item.ghost_in | cfg.point_hidden_flag;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.func == FUNC_LOAD || in_data.func == FUNC_POINT ||
              in_data.func == FUNC_CELL) begin
            state_next = S_PSL;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_PSL: state_next = S_TOT;
      S_TOT: state_next = (item.func == FUNC_CELL) ? S_CSL : S_PCHK;
      S_PCHK: begin
        if (alu_rsp.ge || idx_over) begin
          state_next = S_DONE;
        end else if (item.func == FUNC_LOAD) begin
          state_next = S_PWR;
        end else begin
          state_next = S_PRD;
        end
      end
      S_PWR:  state_next = S_DONE;
      S_PRD:  state_next = S_PDAT;
      S_PDAT: state_next = S_DONE;
      S_CSL:  state_next = S_CCNT;
      S_CCNT: state_next = S_CCHK;
      S_CCHK: state_next = alu_rsp.ge ? S_DONE : S_DIV1;
      S_DIV1: state_next = (step == STEP_LAST) ? S_DIV2 : S_DIV1;
      S_DIV2: state_next = (step == STEP_LAST) ? S_B1 : S_DIV2;
      S_B1:   state_next = S_B2;
      S_B2:   state_next = S_B3;
      S_B3:   state_next = S_B4;
      S_B4:   state_next = S_T1;
      S_T1:   state_next = S_T2;
      S_T2:   state_next = S_T3;
      S_T3:   state_next = (alu_rsp.ge || acc_over) ? S_DONE : S_CA;
      S_CA:   state_next = S_CB;
      S_CB:   state_next = S_CRD;
      S_CRD:  state_next = S_CORN;
      S_CORN: state_next = (corner == 3'd7) ? S_DONE : S_CA;
      S_DONE: state_next = res_take ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // ALU and memory controls.
  always_comb begin
    alu_req.op  = ALU_ADD;
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.cin = 1'b0;
    mem_req.we   = 1'b0;
    mem_req.wbit = item.mask_bit;
    mem_addr     = acc[AW-1:0];
    case (state)
      S_PSL: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = VW'(cfg.points_x);
        alu_req.b  = VW'(cfg.points_y);
      end
      S_TOT: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = pslice;
        alu_req.b  = VW'(cfg.points_z);
      end
      S_PCHK: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = idx_v;
        alu_req.b  = total;
      end
      S_PWR: begin
        mem_req.we = 1'b1;
        mem_addr   = idx_v[AW-1:0];
      end
      S_PRD: begin
        mem_addr = idx_v[AW-1:0];
      end
      S_CSL: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = VW'(cx);
        alu_req.b  = VW'(cy);
      end
      S_CCNT: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = cslice;
        alu_req.b  = VW'(cz);
      end
      S_CCHK: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = idx_v;
        alu_req.b  = acc;
      end
      S_DIV1: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = div_a;
        alu_req.b  = cslice;
      end
      S_DIV2: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = div_a;
        alu_req.b  = VW'(cx);
      end
      S_B1: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = VW'(cj);
        alu_req.b  = VW'(cfg.points_x);
      end
      S_B2: begin
        alu_req.a = VW'(ci);
        alu_req.b = acc;
      end
      S_B3: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = pslice;
        alu_req.b  = VW'(ck);
      end
      S_B4: begin
        alu_req.a = base;
        alu_req.b = acc;
      end
      S_T1: begin
        alu_req.a   = base;
        alu_req.b   = dy ? VW'(cfg.points_x) : '0;
        alu_req.cin = dx;
      end
      S_T2: begin
        alu_req.a = acc;
        alu_req.b = dz ? pslice : '0;
      end
      S_T3: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = acc;
        alu_req.b  = total;
      end
      S_CA: begin
        alu_req.a = base;
        alu_req.b = (corner[2] && dz) ? pslice : '0;
      end
      S_CB: begin
        alu_req.a   = acc;
        alu_req.b   = (corner[1] && dy) ? VW'(cfg.points_x) : '0;
        alu_req.cin = corner[0] && dx;
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          item       <= in_data;
          res_hidden <= 1'b0;
          res_bad    <= 1'b0;
        end
      end
      S_PSL: pslice <= alu_rsp.res;
      S_TOT: total  <= alu_rsp.res;
      S_PCHK: begin
        res_bad <= alu_rsp.ge || idx_over;
      end
      S_PDAT: begin
        res_hidden <= !mem_rdata;
      end
      S_CSL:  cslice <= alu_rsp.res;
      S_CCNT: acc    <= alu_rsp.res;
      S_CCHK: begin
        res_bad <= alu_rsp.ge;
        rem     <= '0;
        quo     <= item.item_index;
        step    <= '0;
      end
      S_DIV1: begin
        step <= step + STEP_W'(1);
        if (step == STEP_LAST) begin
          // Split off k, then start the j/i split on the remainder.
          ck  <= {quo[IDX_W-2:0], alu_rsp.ge};
          quo <= alu_rsp.res[IDX_W-1:0];
          rem <= '0;
        end else begin
          quo <= {quo[IDX_W-2:0], alu_rsp.ge};
          rem <= alu_rsp.res;
        end
      end
      S_DIV2: begin
        step <= step + STEP_W'(1);
        quo  <= {quo[IDX_W-2:0], alu_rsp.ge};
        rem  <= alu_rsp.res;
        if (step == STEP_LAST) begin
          cj <= {quo[IDX_W-2:0], alu_rsp.ge};
          ci <= alu_rsp.res[IDX_W-1:0];
        end
      end
      S_B1: acc  <= alu_rsp.res;
      S_B2: base <= alu_rsp.res;
      S_B3: acc  <= alu_rsp.res;
      S_B4: base <= alu_rsp.res;
      S_T1: acc  <= alu_rsp.res;
      S_T2: acc  <= alu_rsp.res;
      S_T3: begin
        res_bad <= alu_rsp.ge || acc_over;
        corner  <= '0;
        all_ok  <= 1'b1;
      end
      S_CA: acc <= alu_rsp.res;
      S_CB: acc <= alu_rsp.res;
      S_CORN: begin
        all_ok <= all_ok && mem_rdata;
        corner <= corner + 3'd1;
        if (corner == 3'd7) begin
          res_hidden <= !(all_ok && mem_rdata);
        end
      end
      default: begin
        step <= step;
      end
    endcase
  end

  `GPCB_ASSERT_NOW(a_corner_in_range, state == S_CRD, acc < DEPTH_V,
    "corner read outside the mask store")
  `GPCB_ASSERT_NOW(a_write_checked, mem_req.we, (idx_v < total) && !idx_over,
    "mask write for an unchecked point id")
  `GPCB_ASSERT_NOW(a_result_exclusive, state == S_DONE, !(res_hidden && res_bad),
    "result flags both hidden and bad index")
  `GPCB_ASSERT_NEXT(a_accept_busy, accept, in_stall,
    "input taken while the sequencer stayed idle")

endmodule

`default_nettype wire

[design/grid_point_cell_blanking_top.sv]
// Top level of the grid point/cell blanking block: configuration registers,
// result register, and the sequencer, shared ALU and mask store beneath.
// Uses gpcb_pkg, gpcb_seq, gpcb_alu and gpcb_mask_mem.
`default_nettype none

// The block holds one valid bit per grid point (MASK_DEPTH bits, one memory
// port) and answers three kinds of transaction: a load writes one mask bit, a
// point transaction ORs point_hidden_flag into ghost_in when that point's bit
// is zero, and a cell transaction splits the cell id into i, j and k and ORs
// cell_hidden_flag in when any of its corner points is invalid. Ids outside
// the grid or the store set bad_index and pass ghost_in through. Exactly one
// result comes back per input transaction, in order. The block works on one
// transaction at a time and stalls its input meanwhile. A cell transaction
// runs through the single shared multiply/add/subtract unit doing one
// operation per cycle, two 16-step restoring divisions for the id split, and
// eight corner reads, each through the states S_CA, S_CB, S_CRD and S_CORN,
// on the one mask port; out-of-range items leave early. A finished result
// sits in the output register, so the next transaction may be accepted
// while it waits to be taken. The mask store comes up undefined: read only
// entries already loaded.
// Configuration writes are always ready and must only occur while idle.

module grid_point_cell_blanking_top #(
  parameter int MASK_DEPTH = 65536
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  gpcb_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output gpcb_pkg::out_item_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gpcb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gpcb_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import gpcb_pkg::*;

  localparam int AW = $clog2(MASK_DEPTH);

  cfg_t      cfg;
  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;
  mem_req_t  mem_req;
  logic [AW-1:0] mem_addr;
  logic      mem_rdata;
  logic      res_valid, res_take;
  out_item_t res_data;

  // Configuration writes are always accepted; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.points_x          <= DIM_W'(10);
      cfg.points_y          <= DIM_W'(10);
      cfg.points_z          <= DIM_W'(10);
      cfg.point_hidden_flag <= FLAG_W'(2);
      cfg.cell_hidden_flag  <= FLAG_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POINTS_X:   cfg.points_x          <= cfg_data[DIM_W-1:0];
        CFG_POINTS_Y:   cfg.points_y          <= cfg_data[DIM_W-1:0];
        CFG_POINTS_Z:   cfg.points_z          <= cfg_data[DIM_W-1:0];
        CFG_POINT_FLAG: cfg.point_hidden_flag <= cfg_data[FLAG_W-1:0];
        CFG_CELL_FLAG:  cfg.cell_hidden_flag  <= cfg_data[FLAG_W-1:0];
        default: begin
          cfg.points_x <= cfg.points_x;
        end
      endcase
    end
  end

  // Move the finished result into the output register when it is empty or
  // being drained this cycle; otherwise hold the sequencer in its done state.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res_data;
    end
  end

  gpcb_seq #(
    .MASK_DEPTH(MASK_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp),
    .mem_req   (mem_req),
    .mem_addr  (mem_addr),
    .mem_rdata (mem_rdata)
  );

  gpcb_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  gpcb_mask_mem #(
    .MASK_DEPTH(MASK_DEPTH)
  ) u_mask_mem (
    .clk   (clk),
    .req   (mem_req),
    .addr  (mem_addr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

[sim/tb_grid_point_cell_blanking_top.sv]
// Self-checking testbench for grid_point_cell_blanking_top: mask loads, point and
// cell blanking under a range of grid settings, with random idling on both sides.
// Depends on gpcb_pkg and the grid_point_cell_blanking_top RTL only.

module tb_grid_point_cell_blanking_top;
  import gpcb_pkg::*;

  localparam int MASK_DEPTH = 65536;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // Idle padding after a drain, well past the length of a cell transaction.
  localparam int SETTLE_PAD = 100;
  localparam int LONG_HOLD = 400;
  localparam int MAX_PRINTED = 40;

  typedef logic [7:0][63:0] corner_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_point_cell_blanking_top #(
    .MASK_DEPTH(MASK_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Transactions waiting to be offered, and blanking results owed by the block.
  in_item_t  items_to_send[$];
  out_item_t results_due[$];

  // Predictor state: grid settings as the block holds them, and its mask bits.
  cfg_t mdl_cfg;
  bit   mask_shadow [0:MASK_DEPTH-1];

  // Generator state: grid settings being sent, and which mask ids hold a bit.
  cfg_t gen_cfg;
  bit   mask_written [0:MASK_DEPTH-1];

  int items_in = 0;
  int queued = 0;
  int results_seen = 0;
  int mismatches = 0;
  int grids = 0;
  int n_load = 0, n_point = 0, n_cell = 0, n_other = 0, n_bad = 0, n_hidden = 0;

  // Idling controls; the quiet flags and hold point are set only while the block is idle.
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int hold_at = -1;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int rx_left = 0;
  int rx_roll;
  int tx_gap = 0;
  out_item_t due_head;

  function automatic cfg_t grid_defaults();
    cfg_t c;
    c.points_x = 17'd10;
    c.points_y = 17'd10;
    c.points_z = 17'd10;
    c.point_hidden_flag = 8'd2;
    c.cell_hidden_flag = 8'd32;
    return c;
  endfunction

  // A point id is usable if it lies inside both the grid and the mask store.
  function automatic bit point_in_grid(cfg_t c, longint unsigned id);
    longint unsigned px, py, pz;
    px = c.points_x;
    py = c.points_y;
    pz = c.points_z;
    return (id < px * py * pz) && (id < MASK_DEPTH);
  endfunction

  // Split a cell id and list its corner points; return 0 when out of range.
  function automatic bit cell_span(cfg_t c, longint unsigned cid,
                                   output corner_set_t corners, output int count);
    longint unsigned px, py, pz, cx, cy, cz, cslice, pslice;
    longint unsigned ck, rem, cj, ci, base, top, dx, dy, dz, i, j, k;
    px = c.points_x;
    py = c.points_y;
    pz = c.points_z;
    cx = (px > 1) ? px - 1 : 1;
    cy = (py > 1) ? py - 1 : 1;
    cz = (pz > 1) ? pz - 1 : 1;
    dx = (px > 1) ? 1 : 0;
    dy = (py > 1) ? 1 : 0;
    dz = (pz > 1) ? 1 : 0;
    cslice = cx * cy;
    pslice = px * py;
    corners = '0;
    count = 0;
    if (cid >= cslice * cz) return 1'b0;
    ck = cid / cslice;
    rem = cid % cslice;
    cj = rem / cx;
    ci = rem % cx;
    base = ci + px * cj + pslice * ck;
    top = base + dx + dy * px + dz * pslice;
    if (!point_in_grid(c, top)) return 1'b0;
    for (k = 0; k <= dz; k++)
      for (j = 0; j <= dy; j++)
        for (i = 0; i <= dx; i++) begin
          corners[count] = base + i + j * px + k * pslice;
          count++;
        end
    return 1'b1;
  endfunction

  // Work out the result of one accepted transaction and advance the mask shadow.
  function automatic out_item_t predict_blanking(in_item_t it);
    out_item_t r;
    corner_set_t corners;
    int count, m;
    bit all_valid;
    r.ghost_out = it.ghost_in;
    r.hidden = 1'b0;
    r.bad_index = 1'b0;
    case (it.func)
      FUNC_LOAD: begin
        n_load++;
        if (point_in_grid(mdl_cfg, it.item_index))
          mask_shadow[it.item_index] = it.mask_bit;
        else
          r.bad_index = 1'b1;
      end
      FUNC_POINT: begin
        n_point++;
        if (!point_in_grid(mdl_cfg, it.item_index)) begin
          r.bad_index = 1'b1;
        end else if (!mask_shadow[it.item_index]) begin
          r.hidden = 1'b1;
          r.ghost_out = it.ghost_in | mdl_cfg.point_hidden_flag;
        end
      end
      FUNC_CELL: begin
        n_cell++;
        if (!cell_span(mdl_cfg, it.item_index, corners, count)) begin
          r.bad_index = 1'b1;
        end else begin
          all_valid = 1'b1;
          for (m = 0; m < count; m++)
            if (!mask_shadow[corners[m]]) all_valid = 1'b0;
          if (!all_valid) begin
            r.hidden = 1'b1;
            r.ghost_out = it.ghost_in | mdl_cfg.cell_hidden_flag;
          end
        end
      end
      default: n_other++;
    endcase
    if (r.bad_index) n_bad++;
    if (r.hidden) n_hidden++;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTED)
      $display("[%0t] mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic int idle_gap(bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Driver: offer queued transactions, hold each until accepted, then idle a while.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      tx_gap <= 0;
      items_in <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        results_due.push_back(predict_blanking(in_data));
        items_in <= items_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          in_valid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (items_to_send.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= items_to_send.pop_front();
          tx_gap <= idle_gap(tx_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold that backs the
  // block up into its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_left <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_in == hold_at) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (rx_quiet) begin
      out_stall <= 1'b0;
      rx_left <= 0;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 45) begin
        out_stall <= 1'b0;
        rx_left <= $urandom_range(0, 6);
      end else if (rx_roll < 85) begin
        out_stall <= 1'b1;
        rx_left <= $urandom_range(0, 2);
      end else if (rx_roll < 97) begin
        out_stall <= 1'b1;
        rx_left <= $urandom_range(5, 15);
      end else begin
        out_stall <= 1'b1;
        rx_left <= $urandom_range(20, 60);
      end
    end
  end

  // Track register writes so the predictor sees the grid the block sees.
  always @(posedge clk) begin
    if (rst) begin
      mdl_cfg <= grid_defaults();
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POINTS_X:   mdl_cfg.points_x <= cfg_data;
        CFG_POINTS_Y:   mdl_cfg.points_y <= cfg_data;
        CFG_POINTS_Z:   mdl_cfg.points_z <= cfg_data;
        CFG_POINT_FLAG: mdl_cfg.point_hidden_flag <= cfg_data[FLAG_W-1:0];
        CFG_CELL_FLAG:  mdl_cfg.cell_hidden_flag <= cfg_data[FLAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Monitor: check each taken result against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        flag_mismatch("result with none outstanding", out_data, 0);
      end else begin
        due_head = results_due.pop_front();
        if (out_data.ghost_out !== due_head.ghost_out)
          flag_mismatch("ghost_out", out_data.ghost_out, due_head.ghost_out);
        if (out_data.hidden !== due_head.hidden)
          flag_mismatch("hidden", out_data.hidden, due_head.hidden);
        if (out_data.bad_index !== due_head.bad_index)
          flag_mismatch("bad_index", out_data.bad_index, due_head.bad_index);
      end
      results_seen++;
    end
  end

  function automatic void queue_item(logic [1:0] f, longint unsigned idx, logic b,
                                     logic [FLAG_W-1:0] g);
    in_item_t it;
    it.func = f;
    it.item_index = idx[IDX_W-1:0];
    it.mask_bit = b;
    it.ghost_in = g;
    items_to_send.push_back(it);
    queued++;
  endfunction

  // Mostly valid bits, so that fully valid cells show up often enough.
  function automatic logic likely_valid();
    return $urandom_range(0, 99) < 85;
  endfunction

  function automatic void queue_load(longint unsigned idx, logic b);
    if (point_in_grid(gen_cfg, idx)) mask_written[idx] = 1'b1;
    queue_item(FUNC_LOAD, idx, b, FLAG_W'($urandom));
  endfunction

  // Point and cell transactions only read loaded entries: load any gaps first.
  function automatic void queue_point(longint unsigned idx, logic [FLAG_W-1:0] g);
    if (point_in_grid(gen_cfg, idx) && !mask_written[idx])
      queue_load(idx, likely_valid());
    queue_item(FUNC_POINT, idx, 1'($urandom), g);
  endfunction

  function automatic void queue_cell(longint unsigned idx, logic [FLAG_W-1:0] g);
    corner_set_t corners;
    int count, m;
    if (cell_span(gen_cfg, idx, corners, count))
      for (m = 0; m < count; m++)
        if (!mask_written[corners[m]]) queue_load(corners[m], likely_valid());
    queue_item(FUNC_CELL, idx, 1'($urandom), g);
  endfunction

  function automatic longint unsigned pick_point();
    longint unsigned px, py, pz, total;
    px = gen_cfg.points_x;
    py = gen_cfg.points_y;
    pz = gen_cfg.points_z;
    total = px * py * pz;
    if (total > MASK_DEPTH) total = MASK_DEPTH;
    if (total == 0) return $urandom_range(0, MASK_DEPTH - 1);
    if ($urandom_range(0, 9) == 0) return total - 1;
    return $urandom_range(0, int'(total - 1));
  endfunction

  function automatic longint unsigned pick_cell();
    longint unsigned px, py, pz, total;
    px = gen_cfg.points_x;
    py = gen_cfg.points_y;
    pz = gen_cfg.points_z;
    total = ((px > 1) ? px - 1 : 1) * ((py > 1) ? py - 1 : 1) * ((pz > 1) ? pz - 1 : 1);
    if (total > MASK_DEPTH) total = MASK_DEPTH;
    if ($urandom_range(0, 9) == 0) return total - 1;
    return $urandom_range(0, int'(total - 1));
  endfunction

  // Mostly well-formed transactions inside the grid, some raw ids and dead codes.
  function automatic void random_item();
    int roll;
    logic [FLAG_W-1:0] g;
    roll = $urandom_range(0, 99);
    g = FLAG_W'($urandom);
    if (roll < 30) begin
      queue_load(pick_point(), likely_valid());
    end else if (roll < 55) begin
      queue_point(pick_point(), g);
    end else if (roll < 85) begin
      queue_cell(pick_cell(), g);
    end else if (roll < 90) begin
      queue_load($urandom_range(0, MASK_DEPTH - 1), 1'($urandom));
    end else if (roll < 93) begin
      queue_point($urandom_range(0, MASK_DEPTH - 1), g);
    end else if (roll < 96) begin
      queue_cell($urandom_range(0, MASK_DEPTH - 1), g);
    end else begin
      queue_item(FUNC_UNUSED, $urandom, 1'($urandom), g);
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Wait until nothing is queued, offered or owed.
  task automatic settle();
    while (items_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk);
  endtask

  // One grid setting: drain, rewrite every register, then send random traffic.
  task automatic run_phase(input int unsigned px, input int unsigned py,
                           input int unsigned pz, input int unsigned pflag,
                           input int unsigned cflag, input int count,
                           input bit quiet_tx, input bit quiet_rx, input bit with_hold);
    int start;
    settle();
    repeat (SETTLE_PAD) @(posedge clk);
    write_reg(CFG_POINTS_X, CFG_DATA_W'(px));
    write_reg(CFG_POINTS_Y, CFG_DATA_W'(py));
    write_reg(CFG_POINTS_Z, CFG_DATA_W'(pz));
    write_reg(CFG_POINT_FLAG, CFG_DATA_W'(pflag));
    write_reg(CFG_CELL_FLAG, CFG_DATA_W'(cflag));
    gen_cfg.points_x = DIM_W'(px);
    gen_cfg.points_y = DIM_W'(py);
    gen_cfg.points_z = DIM_W'(pz);
    gen_cfg.point_hidden_flag = FLAG_W'(pflag);
    gen_cfg.cell_hidden_flag = FLAG_W'(cflag);
    grids++;
    @(negedge clk);
    tx_quiet = quiet_tx;
    rx_quiet = quiet_rx;
    if (with_hold) hold_at = items_in + 12;
    start = queued;
    while (queued - start < count) random_item();
    settle();
  endtask

  initial begin
    gen_cfg = grid_defaults();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, on the reset grid of 10 x 10 x 10: first and last point, points
    // just past the grid and at the top of the id range, first and last cell,
    // cells past the end, and the unused function code.
    queue_load(0, 1'b1);
    queue_load(999, 1'b0);
    queue_load(1000, 1'b1);
    queue_load(65535, 1'b1);
    queue_point(0, 8'hFF);
    queue_point(999, 8'h00);
    queue_point(1000, 8'h5A);
    queue_point(65535, 8'h00);
    queue_cell(0, 8'h00);
    queue_cell(728, 8'hC3);
    queue_cell(729, 8'h00);
    queue_cell(65535, 8'hFF);
    queue_item(FUNC_UNUSED, 16'hFFFF, 1'b1, 8'hA5);
    settle();

    // Reset grid again, then small, single-point and one-axis extremes.
    run_phase(10, 10, 10, 8'h02, 8'h20, 80, 1'b0, 1'b0, 1'b0);
    run_phase(2, 2, 2, 8'hFF, 8'h00, 70, 1'b1, 1'b1, 1'b0);
    run_phase(1, 1, 1, 8'h00, 8'hFF, 40, 1'b0, 1'b0, 1'b0);
    run_phase(65536, 1, 1, 8'h81, 8'h7E, 80, 1'b0, 1'b0, 1'b0);
    run_phase(1, 65536, 1, $urandom_range(0, 255), $urandom_range(0, 255),
              60, 1'b0, 1'b0, 1'b0);
    run_phase(1, 1, 65536, $urandom_range(0, 255), $urandom_range(0, 255),
              60, 1'b0, 1'b0, 1'b0);
    // Keep offering back to back while the receiver holds off for a long stretch.
    run_phase(17, 13, 9, $urandom_range(0, 255), $urandom_range(0, 255),
              100, 1'b1, 1'b0, 1'b1);
    run_phase(256, 256, 1, $urandom_range(0, 255), $urandom_range(0, 255),
              80, 1'b0, 1'b0, 1'b0);
    // Grid larger than the mask store: every cell reaches past its end.
    run_phase(300, 300, 3, $urandom_range(0, 255), $urandom_range(0, 255),
              80, 1'b0, 1'b0, 1'b0);
    run_phase(65536, 65536, 65536, 8'hFF, 8'hFF, 60, 1'b0, 1'b0, 1'b0);
    // Zero point size: every id is out of range.
    run_phase(0, 5, 7, $urandom_range(0, 255), $urandom_range(0, 255),
              30, 1'b0, 1'b0, 1'b0);
    run_phase(40, 40, 40, $urandom_range(0, 255), $urandom_range(0, 255),
              80, 1'b0, 1'b1, 1'b0);
    run_phase(3, 1, 4, $urandom_range(0, 255), $urandom_range(0, 255),
              60, 1'b0, 1'b0, 1'b0);

    settle();
    repeat (SETTLE_PAD) @(posedge clk);
    $display("Sent %0d transactions over %0d grid settings:", items_in, grids + 1);
    $display("  %0d loads, %0d point, %0d cell, %0d unused code",
             n_load, n_point, n_cell, n_other);
    $display("Checked %0d results: %0d out of range, %0d marked hidden, %0d mismatches",
             results_seen, n_bad, n_hidden, mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("** grid_point_cell_blanking_top: PASSED **");
    end else begin
      $display("** grid_point_cell_blanking_top: FAILED **");
    end
    $finish;
  end

  // Watchdog: a correct run ends far sooner than this.
  initial begin
    #8000000;
    $display("Timed out with %0d results outstanding", results_due.size());
    $display("** grid_point_cell_blanking_top: FAILED **");
    $finish;
  end

endmodule
